// ===== hw/rtl/postfix_expression_evaluator_top_assert.svh =====
// Assertion macros shared by the evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("evaluator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("evaluator assertion failed");

`endif

// ===== hw/rtl/pee_pkg.sv =====
`timescale 1ns / 1ps

package pee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int MAX_DIGITS  = 9;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 30;
    localparam int DIG_W       = 4;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int PC_W        = 5;

    localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_STACK    = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    // Program step addresses.
    localparam logic [PC_W-1:0] STEP_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] STEP_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] STEP_CLOSE    = 5'd2;
    localparam logic [PC_W-1:0] STEP_OP_CHECK = 5'd3;
    localparam logic [PC_W-1:0] STEP_SP_CHECK = 5'd4;
    localparam logic [PC_W-1:0] STEP_READ_A   = 5'd5;
    localparam logic [PC_W-1:0] STEP_READ_B   = 5'd6;
    localparam logic [PC_W-1:0] STEP_LATCH_B  = 5'd7;
    localparam logic [PC_W-1:0] STEP_Z_CHECK  = 5'd8;
    localparam logic [PC_W-1:0] STEP_DIV_GO   = 5'd9;
    localparam logic [PC_W-1:0] STEP_DIV_WAIT = 5'd10;
    localparam logic [PC_W-1:0] STEP_DIV_PUSH = 5'd11;
    localparam logic [PC_W-1:0] STEP_ALU      = 5'd12;
    localparam logic [PC_W-1:0] STEP_DIV_ZERO = 5'd13;
    localparam logic [PC_W-1:0] STEP_OP_ERR   = 5'd14;
    localparam logic [PC_W-1:0] STEP_FINISH   = 5'd15;
    localparam logic [PC_W-1:0] STEP_F_CLOSE  = 5'd16;
    localparam logic [PC_W-1:0] STEP_F_READ   = 5'd17;
    localparam logic [PC_W-1:0] STEP_EMIT     = 5'd18;
    localparam logic [PC_W-1:0] STEP_RETRY    = 5'd19;
    localparam logic [PC_W-1:0] STEP_DIGIT    = 5'd20;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_WAIT,
        UOP_CLOSE,
        UOP_READ_A,
        UOP_READ_B,
        UOP_LATCH_B,
        UOP_DIV_START,
        UOP_PUSH_DIV,
        UOP_PUSH_ALU,
        UOP_PUSH_DZ,
        UOP_ERR_STACK,
        UOP_READ_BOTTOM,
        UOP_EMIT,
        UOP_DIGIT
    } uop_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_NO_ACCEPT,
        COND_DIGIT,
        COND_NOT_OP,
        COND_SP_LT2,
        COND_NOT_DIV,
        COND_A_ZERO,
        COND_DIV_BUSY,
        COND_NOT_LAST,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Control store: taken jumps go to target, otherwise to the next step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{uop: UOP_NONE, cond: COND_ALWAYS, target: STEP_WAIT};
        unique case (pc)
            STEP_WAIT:     cw = '{UOP_WAIT,        COND_NO_ACCEPT, STEP_WAIT};
            STEP_DISPATCH: cw = '{UOP_NONE,        COND_DIGIT,     STEP_DIGIT};
            STEP_CLOSE:    cw = '{UOP_CLOSE,       COND_NEVER,     STEP_WAIT};
            STEP_OP_CHECK: cw = '{UOP_NONE,        COND_NOT_OP,    STEP_FINISH};
            STEP_SP_CHECK: cw = '{UOP_NONE,        COND_SP_LT2,    STEP_OP_ERR};
            STEP_READ_A:   cw = '{UOP_READ_A,      COND_NEVER,     STEP_WAIT};
            STEP_READ_B:   cw = '{UOP_READ_B,      COND_NEVER,     STEP_WAIT};
            STEP_LATCH_B:  cw = '{UOP_LATCH_B,     COND_NOT_DIV,   STEP_ALU};
            STEP_Z_CHECK:  cw = '{UOP_NONE,        COND_A_ZERO,    STEP_DIV_ZERO};
            STEP_DIV_GO:   cw = '{UOP_DIV_START,   COND_NEVER,     STEP_WAIT};
            STEP_DIV_WAIT: cw = '{UOP_NONE,        COND_DIV_BUSY,  STEP_DIV_WAIT};
            STEP_DIV_PUSH: cw = '{UOP_PUSH_DIV,    COND_ALWAYS,    STEP_FINISH};
            STEP_ALU:      cw = '{UOP_PUSH_ALU,    COND_ALWAYS,    STEP_FINISH};
            STEP_DIV_ZERO: cw = '{UOP_PUSH_DZ,     COND_ALWAYS,    STEP_FINISH};
            STEP_OP_ERR:   cw = '{UOP_ERR_STACK,   COND_NEVER,     STEP_WAIT};
            STEP_FINISH:   cw = '{UOP_NONE,        COND_NOT_LAST,  STEP_WAIT};
            STEP_F_CLOSE:  cw = '{UOP_CLOSE,       COND_NEVER,     STEP_WAIT};
            STEP_F_READ:   cw = '{UOP_READ_BOTTOM, COND_NEVER,     STEP_WAIT};
            STEP_EMIT:     cw = '{UOP_EMIT,        COND_OUT_FREE,  STEP_WAIT};
            STEP_RETRY:    cw = '{UOP_NONE,        COND_ALWAYS,    STEP_EMIT};
            STEP_DIGIT:    cw = '{UOP_DIGIT,       COND_ALWAYS,    STEP_FINISH};
            default:       cw = '{UOP_NONE,        COND_ALWAYS,    STEP_WAIT};
        endcase
        return cw;
    endfunction

endpackage

// ===== hw/rtl/postfix_expression_evaluator_top.sv =====
`timescale 1ns / 1ps

// Postfix evaluator: one ASCII character per item, the final character flagged by
// s_is_last, one result item (value and error code) per expression. A small control
// program steps a stack datapath; the stack is a 32-entry RAM with a registered read
// port. Each character runs a short sequence of program steps; / also waits for the
// 32 iterations of the bit-serial divider. The final character adds steps for the
// closing push, the bottom-of-stack read and the result write; the result register
// frees the input side while a result waits.
module postfix_expression_evaluator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_char_code,
    input  logic                        s_is_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pee_pkg::DATA_W-1:0]  m_value,
    output logic [1:0]                  m_error_code
);
    import pee_pkg::*;

    `include "postfix_expression_evaluator_top_assert.svh"

    // Sequencer
    logic [PC_W-1:0]   pc_reg, pc_next;
    ctrl_word_t        cw;
    logic              jump;

    // Datapath
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [1:0]        err_reg, err_next;
    logic [7:0]        ch_reg;
    logic              last_reg;
    logic [DATA_W-1:0] a_reg, b_reg;

    logic              push_req, push_ok;
    logic [DATA_W-1:0] push_data;
    logic              raise_en;
    logic [1:0]        raise_code;

    logic              is_digit, is_op, is_div;
    logic              accept;
    logic              out_free;
    logic [DATA_W-1:0] alu_result;

    // Divider
    logic                 div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DATA_W-1:0]    div_rem_reg, div_quo_reg, div_den_reg;
    logic                 div_neg_reg;
    logic [DATA_W:0]      div_shift, div_trial;
    logic [DATA_W-1:0]    div_result;

    // Output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic [1:0]        m_error_code_reg;
    logic [1:0]        final_err;

    assign cw       = ucode(pc_reg);
    assign s_ready  = (cw.uop == UOP_WAIT);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_div   = (ch_reg == CH_SLASH);
    assign is_op    = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS) ||
                      (ch_reg == CH_STAR) || is_div;

    always_comb begin
        unique case (cw.cond)
            COND_ALWAYS:    jump = 1'b1;
            COND_NEVER:     jump = 1'b0;
            COND_NO_ACCEPT: jump = !accept;
            COND_DIGIT:     jump = is_digit;
            COND_NOT_OP:    jump = !is_op;
            COND_SP_LT2:    jump = (sp_reg < SP_W'(2));
            COND_NOT_DIV:   jump = !is_div;
            COND_A_ZERO:    jump = (a_reg == '0);
            COND_DIV_BUSY:  jump = div_busy_reg;
            COND_NOT_LAST:  jump = !last_reg;
            COND_OUT_FREE:  jump = out_free;
            default:        jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + PC_W'(1);
    end

    always_comb begin
        case (ch_reg)
            CH_PLUS:  alu_result = b_reg + a_reg;
            CH_MINUS: alu_result = b_reg - a_reg;
            default:  alu_result = b_reg * a_reg;
        endcase
    end

    assign div_result = div_neg_reg ? (~div_quo_reg + DATA_W'(1)) : div_quo_reg;
    assign div_shift  = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_trial  = div_shift - {1'b0, div_den_reg};

    // Pushes and error raises requested by the current step.
    always_comb begin
        push_req   = 1'b0;
        push_data  = '0;
        raise_en   = 1'b0;
        raise_code = ERR_NONE;
        unique case (cw.uop)
            UOP_CLOSE: begin
                push_req  = (dig_reg != '0);
                push_data = DATA_W'(acc_reg);
            end
            UOP_PUSH_DIV: begin
                push_req  = 1'b1;
                push_data = div_result;
            end
            UOP_PUSH_ALU: begin
                push_req  = 1'b1;
                push_data = alu_result;
            end
            UOP_PUSH_DZ: begin
                push_req   = 1'b1;
                raise_en   = 1'b1;
                raise_code = ERR_DIV_ZERO;
            end
            UOP_ERR_STACK: begin
                raise_en   = 1'b1;
                raise_code = ERR_STACK;
            end
            UOP_DIGIT: begin
                raise_en   = (dig_reg >= DIG_W'(MAX_DIGITS));
                raise_code = ERR_TOO_LONG;
            end
            default: begin
            end
        endcase
        push_ok = push_req && (sp_reg < SP_W'(STACK_DEPTH));
        // A full stack drops the value; that is the only push that can fail.
        if (push_req && !push_ok) begin
            raise_en   = 1'b1;
            raise_code = ERR_STACK;
        end
    end

    always_comb begin
        unique case (cw.uop)
            UOP_READ_A: rd_addr = ADDR_W'(sp_reg - SP_W'(1));
            UOP_READ_B: rd_addr = ADDR_W'(sp_reg - SP_W'(2));
            default:    rd_addr = '0;
        endcase
    end

    assign final_err = (err_reg != ERR_NONE) ? err_reg :
                       ((sp_reg != SP_W'(1)) ? ERR_STACK : ERR_NONE);

    always_comb begin
        sp_next  = sp_reg;
        acc_next = acc_reg;
        dig_next = dig_reg;
        err_next = err_reg;
        if (raise_en && (err_reg == ERR_NONE)) begin
            err_next = raise_code;
        end
        if (push_ok) begin
            sp_next = sp_reg + SP_W'(1);
        end
        if (cw.uop == UOP_CLOSE) begin
            acc_next = '0;
            dig_next = '0;
        end
        if (cw.uop == UOP_LATCH_B) begin
            sp_next = sp_reg - SP_W'(2);
        end
        if ((cw.uop == UOP_DIGIT) && (dig_reg < DIG_W'(MAX_DIGITS))) begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(ch_reg[3:0]);
            dig_next = dig_reg + DIG_W'(1);
        end
        if ((cw.uop == UOP_EMIT) && out_free) begin
            sp_next  = '0;
            acc_next = '0;
            dig_next = '0;
            err_next = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            stack_mem[sp_reg[ADDR_W-1:0]] <= push_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= STEP_WAIT;
            sp_reg  <= '0;
            acc_reg <= '0;
            dig_reg <= '0;
            err_reg <= ERR_NONE;
        end else begin
            pc_reg  <= pc_next;
            sp_reg  <= sp_next;
            acc_reg <= acc_next;
            dig_reg <= dig_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ch_reg   <= s_char_code;
            last_reg <= s_is_last;
        end
        if (cw.uop == UOP_READ_B) begin
            a_reg <= rd_data_reg;
        end
        if (cw.uop == UOP_LATCH_B) begin
            b_reg <= rd_data_reg;
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cw.uop == UOP_DIV_START) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (div_cnt_reg == DIV_CNT_W'(DATA_W - 1)) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.uop == UOP_DIV_START) begin
            div_rem_reg <= '0;
            div_quo_reg <= b_reg[DATA_W-1] ? (~b_reg + DATA_W'(1)) : b_reg;
            div_den_reg <= a_reg[DATA_W-1] ? (~a_reg + DATA_W'(1)) : a_reg;
            div_neg_reg <= a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        end else if (div_busy_reg) begin
            if (!div_trial[DATA_W]) begin
                div_rem_reg <= div_trial[DATA_W-1:0];
                div_quo_reg <= {div_quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_shift[DATA_W-1:0];
                div_quo_reg <= {div_quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cw.uop == UOP_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cw.uop == UOP_EMIT) && out_free) begin
            m_error_code_reg <= final_err;
            m_value_reg      <= (final_err != ERR_NONE) ? INT_MAX : rd_data_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_error_code = m_error_code_reg;

    `PEE_ASSERT_NOW(a_sp_in_range, aclk, aresetn, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `PEE_ASSERT_NOW(a_ready_div_idle, aclk, aresetn, s_ready, !div_busy_reg)
    `PEE_ASSERT_NEXT(a_accept_dispatch, aclk, aresetn, accept, pc_reg == STEP_DISPATCH)
    `PEE_ASSERT_NOW(a_result_from_emit, aclk, aresetn, $rose(m_valid_reg), $past(pc_reg) == STEP_EMIT)
    `PEE_ASSERT_NOW(a_error_value, aclk, aresetn, m_valid_reg && (m_error_code_reg != ERR_NONE), m_value_reg == INT_MAX)

endmodule
